[sv/sfb_pkg.sv]
// Package: transfer types and constants for the serial frame builder.
`timescale 1ns / 1ps

package sfb_pkg;

   localparam logic       OP_START     = 1'b0;
   localparam logic       OP_PAYLOAD   = 1'b1;

   localparam int         CSR_INDEX_W  = 1;
   localparam logic [0:0] CSR_SOF_FIRST  = 1'b0;
   localparam logic [0:0] CSR_SOF_SECOND = 1'b1;

   localparam int         BURST_DEPTH  = 6;
   localparam int         BURST_CNT_W  = 3;
   localparam logic [7:0] LEN_ADJUST   = 8'd3;

   typedef struct packed {
      logic       op;
      logic [7:0] command;
      logic [7:0] payload_len;
      logic       use_given_seq;
      logic [7:0] seq_value;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } rsp_type;

endpackage

[sv/serial_frame_builder_xor_checksum_core.sv]
// Top level: serial frame builder with sequence counter and XOR checksum.
`timescale 1ns / 1ps

// A start transfer (op 0) emits SOF1, SOF2, length+3, sequence and command, and
// the checksum byte too when the payload length is zero; each payload transfer
// emits its byte and, on the last one, the checksum with frame_end set. A
// transfer is taken into a six-entry burst buffer and its bytes leave through
// the output register one per cycle unless rsp_stall holds. The next request
// is accepted in the cycle that the last buffered byte moves to the output
// register, so payload transfers run at one per cycle unless rsp_stall holds;
// a final payload transfer fills two buffer entries and a start transfer five
// (six with an empty payload). Payload bytes with no frame open are taken and
// dropped. The sof registers may be written at any time the block is idle.
module serial_frame_builder_xor_checksum_core #(
   parameter int MAX_PAYLOAD = 252
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sfb_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sfb_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sfb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [7:0]                       csr_wdata
);

   localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

   logic [7:0] sof_first_ff, sof_second_ff;
   logic [7:0] seq_ff, seq_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] left_ff, left_in;
   logic       open_ff, open_in;

   logic [7:0]                      burst_byte_ff [sfb_pkg::BURST_DEPTH];
   logic [7:0]                      burst_byte_in [sfb_pkg::BURST_DEPTH];
   logic [sfb_pkg::BURST_DEPTH-1:0] burst_end_ff, burst_end_in;
   logic [sfb_pkg::BURST_CNT_W-1:0] burst_cnt_ff, burst_cnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   sfb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic       pop, burst_free, req_take;
   logic [7:0] len_sat, pay_xor, pay_left;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sof_first_ff  <= 8'h00;
         sof_second_ff <= 8'h00;
      end else if (csr_valid) begin
         case (csr_index)
            sfb_pkg::CSR_SOF_FIRST:  sof_first_ff  <= csr_wdata;
            sfb_pkg::CSR_SOF_SECOND: sof_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign pop        = (burst_cnt_ff != '0) && (!rsp_valid_ff || !rsp_stall);
   assign burst_free = (burst_cnt_ff == '0) ||
                       ((burst_cnt_ff == sfb_pkg::BURST_CNT_W'(1)) && pop);
   assign req_take   = req_valid && burst_free;
   assign req_stall  = !burst_free;

   assign len_sat  = (req_data.payload_len > MaxLen) ? MaxLen : req_data.payload_len;
   assign pay_xor  = xor_ff ^ req_data.data_byte;
   assign pay_left = left_ff - 8'd1;

   always_comb begin
      seq_in       = seq_ff;
      xor_in       = xor_ff;
      left_in      = left_ff;
      open_in      = open_ff;
      burst_end_in = burst_end_ff;
      burst_cnt_in = burst_cnt_ff;
      for (int i = 0; i < sfb_pkg::BURST_DEPTH; i++) begin
         burst_byte_in[i] = burst_byte_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < sfb_pkg::BURST_DEPTH - 1; i++) begin
            burst_byte_in[i] = burst_byte_ff[i+1];
         end
         burst_end_in = burst_end_ff >> 1;
         burst_cnt_in = burst_cnt_ff - sfb_pkg::BURST_CNT_W'(1);
      end
      if (req_take) begin
         burst_end_in = '0;
         burst_cnt_in = '0;
         if (req_data.op == sfb_pkg::OP_START) begin
            seq_in  = req_data.use_given_seq ? req_data.seq_value : seq_ff + 8'd1;
            xor_in  = req_data.command;
            left_in = len_sat;
            open_in = (len_sat != 8'd0);
            burst_byte_in[0] = sof_first_ff;
            burst_byte_in[1] = sof_second_ff;
            burst_byte_in[2] = len_sat + sfb_pkg::LEN_ADJUST;
            burst_byte_in[3] = seq_in;
            burst_byte_in[4] = req_data.command;
            burst_byte_in[5] = req_data.command;
            burst_end_in[5]  = 1'b1;
            burst_cnt_in     = (len_sat == 8'd0) ? sfb_pkg::BURST_CNT_W'(6)
                                                 : sfb_pkg::BURST_CNT_W'(5);
         end else if (open_ff) begin
            xor_in  = pay_xor;
            left_in = pay_left;
            open_in = (pay_left != 8'd0);
            burst_byte_in[0] = req_data.data_byte;
            burst_byte_in[1] = pay_xor;
            burst_end_in[1]  = 1'b1;
            burst_cnt_in     = (pay_left == 8'd0) ? sfb_pkg::BURST_CNT_W'(2)
                                                  : sfb_pkg::BURST_CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.frame_byte = burst_byte_ff[0];
         rsp_data_in.frame_end  = burst_end_ff[0];
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= 8'h00;
         xor_ff       <= 8'h00;
         left_ff      <= 8'h00;
         open_ff      <= 1'b0;
         burst_cnt_ff <= '0;
         burst_end_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         xor_ff       <= xor_in;
         left_ff      <= left_in;
         open_ff      <= open_in;
         burst_cnt_ff <= burst_cnt_in;
         burst_end_ff <= burst_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < sfb_pkg::BURST_DEPTH; i++) begin
         burst_byte_ff[i] <= burst_byte_in[i];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_burst_depth: assert property (@(posedge clock) disable iff (reset)
      burst_cnt_ff <= sfb_pkg::BURST_CNT_W'(sfb_pkg::BURST_DEPTH))
      else $error("burst count overflow");

   a_open_left: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (left_ff != 8'd0))
      else $error("open frame with no bytes left");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (burst_cnt_ff > sfb_pkg::BURST_CNT_W'(1)) |-> !burst_end_ff[0])
      else $error("frame end before last buffered byte");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (burst_cnt_ff > sfb_pkg::BURST_CNT_W'(1)) |-> req_stall)
      else $error("request taken while burst pending");

endmodule
